@@ design/rrl_pkg.sv @@
`timescale 1ns / 1ps
package rrl_pkg;

  // Field widths
  localparam int CoordW   = 21;            // signed Q8.12 coordinate
  localparam int OffW     = CoordW + 1;    // difference of two coordinates
  localparam int FracW    = 12;
  localparam int DenW     = 44;            // magnitude of dir.normal
  localparam int NumW     = 57;            // -num << 12 when positive
  localparam int DepthW   = 32;            // unsigned Q20.12
  localparam int ChanW    = 16;
  localparam int HalfW    = 20;
  localparam int RadW     = 3 * ChanW;
  localparam int VecW     = 3 * CoordW;
  localparam int InDataW  = 128;
  localparam int OutDataW = DepthW + RadW;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = VecW;

  localparam int DefQueueDepth = 4;

  localparam logic [DepthW-1:0] DepthMiss = '1;
  localparam logic [DepthW-1:0] DepthMax  = {{(DepthW-1){1'b1}}, 1'b0};

  // Configuration register map
  typedef enum logic [CfgIdxW-1:0] {
    RegCenter   = 3'd0,
    RegNormal   = 3'd1,
    RegTanU     = 3'd2,
    RegTanV     = 3'd3,
    RegHalfW    = 3'd4,
    RegHalfH    = 3'd5,
    RegRadiance = 3'd6
  } reg_idx_t;

  // x in the lowest bits, then y, then z
  typedef logic [2:0][CoordW-1:0] vec_t;
  typedef logic [2:0][OffW-1:0]   offv_t;

  typedef struct packed {
    vec_t             center;
    vec_t             normal;
    vec_t             tan_u;
    vec_t             tan_v;
    logic [HalfW-1:0] half_w;
    logic [HalfW-1:0] half_h;
    logic [RadW-1:0]  radiance;
  } rect_t;

  // What rides alongside the divide
  typedef struct packed {
    logic  miss;
    offv_t oc;     // origin - center
    vec_t  dir;
  } tag_t;

  // Word handed from the front end to the back end
  typedef struct packed {
    tag_t            tag;
    logic [NumW-1:0] nn;
    logic [DenW-1:0] dd;
  } work_t;

  // a - b, widened by one bit
  function automatic logic [OffW-1:0] sub_coord(input logic [CoordW-1:0] a,
                                                input logic [CoordW-1:0] b);
    logic signed [OffW-1:0] ea;
    logic signed [OffW-1:0] eb;
    begin
      ea = $signed({a[CoordW-1], a});
      eb = $signed({b[CoordW-1], b});
      return ea - eb;
    end
  endfunction

endpackage

@@ design/rrl_front.sv @@
`timescale 1ns / 1ps
module rrl_front
  import rrl_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [InDataW-1:0] s_tdata,
  input  rect_t              rect,
  output logic               push_valid,
  input  logic               push_ready,
  output work_t              push_data
);

  localparam int ProdW = 2 * CoordW;       // dir * normal
  localparam int CnW   = OffW + CoordW;    // (c - o) * normal
  localparam int DsumW = ProdW + 2;
  localparam int NsumW = CnW + 2;
  localparam int WideW = NumW + 1;

  vec_t org_w;
  vec_t dir_w;
  logic en;

  assign org_w = s_tdata[VecW-1:0];
  assign dir_w = s_tdata[2*VecW-1:VecW];

  // pipe moves unless the last stage is blocked by a full queue
  assign en       = !push_valid || push_ready;
  assign s_tready = en;

  logic                    v1, v2, v3;
  logic signed [ProdW-1:0] dn1 [3];
  logic signed [OffW-1:0]  co1 [3];
  offv_t                   oc1, oc2, oc3;
  vec_t                    dir1, dir2, dir3;
  logic signed [DsumW-1:0] denom2, denom3;
  logic signed [CnW-1:0]   cn2 [3];
  logic signed [NsumW-1:0] num3;

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // stage 1: dir.normal products and offsets
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dn1[i] <= $signed(dir_w[i]) * $signed(rect.normal[i]);
        co1[i] <= $signed(sub_coord(rect.center[i], org_w[i]));
        oc1[i] <= sub_coord(org_w[i], rect.center[i]);
      end
      dir1 <= dir_w;
    end
  end

  // stage 2: denominator sum, numerator products
  always_ff @(posedge clk) begin
    if (en) begin
      denom2 <= DsumW'(dn1[0]) + DsumW'(dn1[1]) + DsumW'(dn1[2]);
      for (int i = 0; i < 3; i++) begin
        cn2[i] <= co1[i] * $signed(rect.normal[i]);
      end
      oc2  <= oc1;
      dir2 <= dir1;
    end
  end

  // stage 3: numerator sum
  always_ff @(posedge clk) begin
    if (en) begin
      num3   <= NsumW'(cn2[0]) + NsumW'(cn2[1]) + NsumW'(cn2[2]);
      denom3 <= denom2;
      oc3    <= oc2;
      dir3   <= dir2;
    end
  end

  // classify: back face, parallel, behind or too close
  logic signed [WideW-1:0] num_ext;
  logic signed [WideW-1:0] nn_full;
  logic signed [WideW-1:0] dd_full;
  logic                    miss;

  always_comb begin
    num_ext = WideW'(num3);
    nn_full = -(num_ext <<< FracW);
    dd_full = -WideW'(denom3);
    miss    = !denom3[DsumW-1] || (nn_full <= dd_full);
  end

  assign push_valid        = v3;
  assign push_data.tag.miss = miss;
  assign push_data.tag.oc   = oc3;
  assign push_data.tag.dir  = dir3;
  assign push_data.nn       = nn_full[NumW-1:0];
  assign push_data.dd       = dd_full[DenW-1:0];

endmodule

@@ design/rrl_queue.sv @@
`timescale 1ns / 1ps
module rrl_queue
  import rrl_pkg::*;
#(
  parameter int Depth = DefQueueDepth
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  work_t push_data,
  output logic  pop_valid,
  input  logic  pop,
  output work_t pop_data
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  work_t           mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count != FullCnt);
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_data   = mem[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

endmodule

@@ design/rrl_div.sv @@
`timescale 1ns / 1ps
module rrl_div
  import rrl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  work_t             in_work,
  output logic              out_valid,
  output logic [DepthW-1:0] out_q,
  output logic              out_sat,
  output tag_t              out_tag
);

  // one quotient bit per stage, restoring
  localparam int HiW = NumW - DepthW;

  logic              vld  [DepthW+1];
  logic [DenW-1:0]   rem  [DepthW+1];
  logic [DenW-1:0]   dvs  [DepthW+1];
  logic [DepthW-1:0] low  [DepthW+1];
  logic [DepthW-1:0] quo  [DepthW+1];
  logic              sat  [DepthW+1];
  tag_t              tag  [DepthW+1];

  logic [DenW-1:0] hi_ext;
  assign hi_ext = DenW'(in_work.nn[NumW-1:DepthW]);

  // entry stage: top bits decide saturation, seed the remainder
  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (en) vld[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= hi_ext;
      dvs[0] <= in_work.dd;
      low[0] <= in_work.nn[DepthW-1:0];
      quo[0] <= '0;
      sat[0] <= (hi_ext >= in_work.dd);
      tag[0] <= in_work.tag;
    end
  end

  for (genvar k = 0; k < DepthW; k++) begin : g_step
    logic [DenW:0] trial;
    logic [DenW:0] diff;
    logic          ge;

    always_comb begin
      trial = {rem[k], low[k][DepthW-1-k]};
      diff  = trial - {1'b0, dvs[k]};
      ge    = trial >= {1'b0, dvs[k]};
    end

    always_ff @(posedge clk) begin
      if (rst) vld[k+1] <= 1'b0;
      else if (en) vld[k+1] <= vld[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? diff[DenW-1:0] : trial[DenW-1:0];
        quo[k+1] <= {quo[k][DepthW-2:0], ge};
        dvs[k+1] <= dvs[k];
        low[k+1] <= low[k];
        sat[k+1] <= sat[k];
        tag[k+1] <= tag[k];
      end
    end
  end

  assign out_valid = vld[DepthW];
  assign out_q     = quo[DepthW];
  assign out_sat   = sat[DepthW];
  assign out_tag   = tag[DepthW];

endmodule

@@ design/rrl_back.sv @@
`timescale 1ns / 1ps
module rrl_back
  import rrl_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                pop_valid,
  output logic                pop,
  input  work_t               pop_data,
  input  rect_t               rect,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata,
  output logic                m_tuser
);

  localparam int PW   = CoordW + DepthW + 1;   // dir * depth
  localparam int SW   = PW + 2;                // offset plus step
  localparam int LocW = SW - FracW;
  localparam int FullW = LocW + CoordW;
  localparam int ProjW = 64;                   // projections wrap at 64 bits

  logic en;
  assign en  = !m_tvalid || m_tready;
  assign pop = en && pop_valid;

  logic              d_valid;
  logic [DepthW-1:0] d_q;
  logic              d_sat;
  tag_t              d_tag;

  rrl_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pop_valid),
    .in_work   (pop_data),
    .out_valid (d_valid),
    .out_q     (d_q),
    .out_sat   (d_sat),
    .out_tag   (d_tag)
  );

  // saturate the quotient
  logic [DepthW-1:0] depth_w;
  assign depth_w = (d_sat || d_q == DepthMiss) ? DepthMax : d_q;

  logic                    mv, lv, pv;
  logic signed [PW-1:0]    mp [3];
  offv_t                   moc;
  logic [DepthW-1:0]       mdepth, ldepth, pdepth;
  logic                    mmiss, lmiss, pmiss;
  logic signed [LocW-1:0]  lloc [3];
  logic [ProjW-1:0]        pu [3];
  logic [ProjW-1:0]        pvv [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= 1'b0;
      lv <= 1'b0;
      pv <= 1'b0;
    end else if (en) begin
      mv <= d_valid;
      lv <= mv;
      pv <= lv;
    end
  end

  // step along the ray
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mp[i] <= $signed(d_tag.dir[i]) * $signed({1'b0, depth_w});
      end
      moc    <= d_tag.oc;
      mdepth <= depth_w;
      mmiss  <= d_tag.miss;
    end
  end

  // hit point relative to the centre, truncated toward zero to Q.12
  logic signed [SW-1:0]   s_sum [3];
  logic signed [LocW-1:0] loc_w [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s_sum[i] = $signed({{(SW-OffW-FracW){moc[i][OffW-1]}}, moc[i], {FracW{1'b0}}})
               + SW'(mp[i]);
      loc_w[i] = s_sum[i][SW-1:FracW]
               + LocW'(s_sum[i][SW-1] && (s_sum[i][FracW-1:0] != '0));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lloc   <= loc_w;
      ldepth <= mdepth;
      lmiss  <= mmiss;
    end
  end

  // tangent products
  logic signed [FullW-1:0] fu [3];
  logic signed [FullW-1:0] fv [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fu[i] = lloc[i] * $signed(rect.tan_u[i]);
      fv[i] = lloc[i] * $signed(rect.tan_v[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pu[i]  <= fu[i][ProjW-1:0];
        pvv[i] <= fv[i][ProjW-1:0];
      end
      pdepth <= ldepth;
      pmiss  <= lmiss;
    end
  end

  // bounds test and result
  logic [ProjW-1:0] lu, lvs, mag_u, mag_v;
  logic [ProjW-1:0] lim_u, lim_v;
  logic             in_u, in_v, hit_w;

  always_comb begin
    lu    = pu[0] + pu[1] + pu[2];
    lvs   = pvv[0] + pvv[1] + pvv[2];
    mag_u = lu[ProjW-1] ? -lu : lu;
    mag_v = lvs[ProjW-1] ? -lvs : lvs;
    lim_u = ProjW'({rect.half_w, {FracW{1'b0}}});
    lim_v = ProjW'({rect.half_h, {FracW{1'b0}}});
    in_u  = $signed(mag_u) <= $signed(lim_u);
    in_v  = $signed(mag_v) <= $signed(lim_v);
    hit_w = !pmiss && in_u && in_v;
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= pv;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tuser <= hit_w;
      m_tdata <= hit_w ? {rect.radiance, pdepth} : {{RadW{1'b0}}, DepthMiss};
    end
  end

endmodule

@@ design/ray_rectangle_light_hit.sv @@
`timescale 1ns / 1ps
// Throughput: one ray per cycle unless the output stalls; the pipelined divider sets the depth.
// The front end and back end stall on their own, joined by a small queue.
// Reset (rst, synchronous) empties the pipes and queue and clears every
// configuration register to zero.
module ray_rectangle_light_hit
  import rrl_pkg::*;
#(
  parameter int QueueDepth = DefQueueDepth
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [InDataW-1:0]  s_tdata,   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata,   // depth, red, green, blue
  output logic                m_tuser,   // hit
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  rect_t rect;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rect <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        RegCenter:   rect.center   <= cfg_data;
        RegNormal:   rect.normal   <= cfg_data;
        RegTanU:     rect.tan_u    <= cfg_data;
        RegTanV:     rect.tan_v    <= cfg_data;
        RegHalfW:    rect.half_w   <= cfg_data[HalfW-1:0];
        RegHalfH:    rect.half_h   <= cfg_data[HalfW-1:0];
        RegRadiance: rect.radiance <= cfg_data[RadW-1:0];
        default: ;
      endcase
    end
  end

  logic  push_valid, push_ready;
  work_t push_data;
  logic  pop_valid, pop;
  work_t pop_data;

  rrl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .rect       (rect),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  rrl_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_data   (pop_data)
  );

  rrl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_data  (pop_data),
    .rect      (rect),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

@@ design/rrl_checker.sv @@
`timescale 1ns / 1ps
module rrl_checker
  import rrl_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic [InDataW-1:0]  s_tdata,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [OutDataW-1:0] m_tdata,
  input logic                m_tuser,
  input logic                cfg_valid,
  input logic                cfg_ready,
  input logic [CfgIdxW-1:0]  cfg_index,
  input logic [CfgDataW-1:0] cfg_data
);

  // a stalled word stays
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  // reset empties the output
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a miss carries infinite depth and no radiance
  a_miss: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |->
      m_tdata[DepthW-1:0] == DepthMiss && m_tdata[OutDataW-1:DepthW] == '0)
    else $error("miss word malformed");

  // a hit depth is finite and beyond zero
  a_hit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |->
      m_tdata[DepthW-1:0] != DepthMiss && m_tdata[DepthW-1:0] != '0)
    else $error("hit depth out of range");

endmodule

bind ray_rectangle_light_hit rrl_checker u_rrl_checker (.*);

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import rrl_pkg::*;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tuser;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  ray_rectangle_light_hit dut (.*);

  always #10 clk = ~clk;

  typedef struct {
    logic        hit;
    logic [31:0] depth;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } shade_t;

  // one row of the directed table: ray, and an optional typed-in answer
  typedef struct {
    logic [125:0] ray;
    bit           fixed;
    shade_t       want;
  } ray_row_t;

  // local copy of the light registers
  logic [62:0] lt_center, lt_normal, lt_tan_u, lt_tan_v;
  logic [19:0] lt_half_w, lt_half_h;
  logic [47:0] lt_rad;

  shade_t      shade_q[$];
  int          errors = 0;
  int          rays_sent = 0, shades_seen = 0, hits_seen = 0;
  int          send_idle = 8, recv_idle = 62;
  bit          hold_off = 0;

  function automatic longint sx(input logic [62:0] p, input int k);
    logic signed [20:0] f;
    f = p[k*21 +: 21];
    return longint'(f);
  endfunction

  // fixed-point ray/rectangle intersection
  function automatic shade_t trace_ray(input logic [125:0] ray);
    shade_t r;
    longint org[3], dir[3], c[3], n[3], u[3], v[3], loc[3];
    longint denom, num, nn, dd, q, lu, lv;
    r = '{0, 32'hFFFF_FFFF, 0, 0, 0};
    for (int i = 0; i < 3; i++) begin
      org[i] = sx(ray[62:0], i);
      dir[i] = sx(ray[125:63], i);
      c[i] = sx(lt_center, i);
      n[i] = sx(lt_normal, i);
      u[i] = sx(lt_tan_u, i);
      v[i] = sx(lt_tan_v, i);
    end
    denom = dir[0]*n[0] + dir[1]*n[1] + dir[2]*n[2];
    if (denom >= 0) return r;
    num = (c[0]-org[0])*n[0] + (c[1]-org[1])*n[1] + (c[2]-org[2])*n[2];
    nn = -num * 4096;
    dd = -denom;
    if (nn <= dd) return r;
    q = nn / dd;
    if (q > 64'sh0_FFFF_FFFE) q = 64'sh0_FFFF_FFFE;
    for (int i = 0; i < 3; i++)
      loc[i] = ((org[i] - c[i]) * 4096 + dir[i] * q) / 4096;
    lu = loc[0]*u[0] + loc[1]*u[1] + loc[2]*u[2];
    lv = loc[0]*v[0] + loc[1]*v[1] + loc[2]*v[2];
    if (lu < 0) lu = -lu;
    if (lv < 0) lv = -lv;
    if (lu > (longint'(lt_half_w) << 12) || lv > (longint'(lt_half_h) << 12)) return r;
    r = '{1, q[31:0], lt_rad[15:0], lt_rad[31:16], lt_rad[47:32]};
    return r;
  endfunction

  function automatic logic [125:0] pack_ray(input longint ox, oy, oz, dx, dy, dz);
    logic [20:0] f[6];
    f = '{ox[20:0], oy[20:0], oz[20:0], dx[20:0], dy[20:0], dz[20:0]};
    return {f[5], f[4], f[3], f[2], f[1], f[0]};
  endfunction

  function automatic logic [62:0] pack_vec(input longint x, y, z);
    return {z[20:0], y[20:0], x[20:0]};
  endfunction

  task automatic write_reg(input reg_idx_t idx, input logic [62:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      RegCenter:   lt_center = val;
      RegNormal:   lt_normal = val;
      RegTanU:     lt_tan_u = val;
      RegTanV:     lt_tan_v = val;
      RegHalfW:    lt_half_w = val[19:0];
      RegHalfH:    lt_half_h = val[19:0];
      RegRadiance: lt_rad = val[47:0];
      default: ;
    endcase
  endtask

  task automatic set_light(input logic [62:0] c, n, u, v, input logic [19:0] hw, hh,
                           input logic [47:0] rad);
    write_reg(RegCenter, c);
    write_reg(RegNormal, n);
    write_reg(RegTanU, u);
    write_reg(RegTanV, v);
    write_reg(RegHalfW, {43'd0, hw});
    write_reg(RegHalfH, {43'd0, hh});
    write_reg(RegRadiance, {15'd0, rad});
  endtask

  // let the pipe drain before touching the registers
  task automatic drain();
    int n;
    n = 0;
    while (shade_q.size() != 0 && n < 200000) begin
      @(posedge clk);
      n++;
    end
    repeat (50) @(posedge clk);
  endtask

  task automatic send_ray(input logic [125:0] ray, input bit fixed, input shade_t want);
    while (send_idle != 0 && $urandom_range(99, 0) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, ray};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    shade_q.push_back(fixed ? want : trace_ray(ray));
    rays_sent++;
  endtask

  function automatic longint rnd_coord();
    case ($urandom_range(5, 0))
      0: return -1048576;
      1: return 1048575;
      2, 3: return $signed($urandom_range(16384, 0)) - 8192;
      default: return $signed($urandom_range(2097151, 0)) - 1048576;
    endcase
  endfunction

  // mostly rays aimed at the light, some arbitrary
  function automatic logic [125:0] rnd_ray();
    longint o[3], d[3];
    if ($urandom_range(3, 0) == 0) begin
      for (int i = 0; i < 3; i++) begin
        o[i] = rnd_coord();
        d[i] = rnd_coord();
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        o[i] = sx(lt_center, i) + sx(lt_normal, i) * $urandom_range(8, 1)
               + $signed($urandom_range(8192, 0)) - 4096;
        d[i] = -sx(lt_normal, i) + $signed($urandom_range(2048, 0)) - 1024;
      end
    end
    return pack_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
  endfunction

  task automatic rnd_phase(input int n);
    for (int k = 0; k < n; k++) send_ray(rnd_ray(), 0, '{0, 0, 0, 0, 0});
    s_tvalid <= 1'b0;
    drain();
  endtask

  // receiver side: random stalls, plus one long hold-off
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= !hold_off && !(recv_idle != 0 && $urandom_range(99, 0) < recv_idle);
  end

  // check each result word against the oldest expectation
  always @(posedge clk) begin
    shade_t e;
    if (!rst && m_tvalid && m_tready) begin
      shades_seen++;
      if (m_tuser) hits_seen++;
      if (shade_q.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = shade_q.pop_front();
        if (m_tuser !== e.hit) begin
          $error("hit: expected %0d got %0d", e.hit, m_tuser); errors++;
        end
        if (m_tdata[31:0] !== e.depth) begin
          $error("depth: expected %h got %h", e.depth, m_tdata[31:0]); errors++;
        end
        if (m_tdata[47:32] !== e.red) begin
          $error("red: expected %h got %h", e.red, m_tdata[47:32]); errors++;
        end
        if (m_tdata[63:48] !== e.green) begin
          $error("green: expected %h got %h", e.green, m_tdata[63:48]); errors++;
        end
        if (m_tdata[79:64] !== e.blue) begin
          $error("blue: expected %h got %h", e.blue, m_tdata[79:64]); errors++;
        end
      end
    end
  end

  initial begin
    #200ms;
    $display("Verification failed");
    $finish;
  end

  localparam longint One = 4096;
  localparam shade_t Miss = '{0, 32'hFFFF_FFFF, 0, 0, 0};

  initial begin
    ray_row_t rows[$];
    shade_t   h;
    lt_center = '0; lt_normal = '0; lt_tan_u = '0; lt_tan_v = '0;
    lt_half_w = '0; lt_half_h = '0; lt_rad = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // registers all zero after reset: every ray misses
    send_ray(pack_ray(0, 0, 0, 0, 0, -One), 1, Miss);
    send_ray(pack_ray(-1048576, 1048575, -1048576, 1048575, -1048576, 1048575), 1, Miss);
    s_tvalid <= 1'b0;
    drain();

    // light facing +z at the origin plane z = 0, 1 x 1 half extents
    set_light(pack_vec(0, 0, 0), pack_vec(0, 0, One), pack_vec(One, 0, 0),
              pack_vec(0, One, 0), 20'd4096, 20'd4096, 48'h3333_2222_1111);
    h = '{1, 32'd8192, 16'h1111, 16'h2222, 16'h3333};
    rows = '{
      '{pack_ray(0, 0, 2*One, 0, 0, -One), 1, h},           // straight down, t = 2
      '{pack_ray(0, 0, 2*One, 0, 0, One), 1, Miss},         // back face
      '{pack_ray(0, 0, 2*One, One, 0, 0), 1, Miss},         // parallel
      '{pack_ray(0, 0, -2*One, 0, 0, -One), 1, Miss},       // light behind ray
      '{pack_ray(0, 0, 1, 0, 0, -One), 1, Miss},            // t of one unit
      '{pack_ray(0, 0, 2, 0, 0, -One), 0, Miss},            // just above one unit
      '{pack_ray(One, One, 2*One, 0, 0, -One), 0, Miss},    // on the corner
      '{pack_ray(One+1, 0, 2*One, 0, 0, -One), 0, Miss},    // just outside u
      '{pack_ray(0, -One-1, 2*One, 0, 0, -One), 0, Miss},   // just outside v
      '{pack_ray(0, 0, 1048575, 0, 0, -1), 0, Miss},        // far hit, just short of saturation
      '{pack_ray(0, 0, 1048575, 0, 0, -1048576), 0, Miss},
      '{pack_ray(-1048576, -1048576, 1048575, 1048575, 1048575, -1048576), 0, Miss},
      '{pack_ray(0, 0, One, 3*One, 0, -One), 0, Miss},      // slanted, non-unit
      '{pack_ray(-One, One, One, One, -One, -One), 0, Miss}
    };
    foreach (rows[i]) send_ray(rows[i].ray, rows[i].fixed, rows[i].want);
    s_tvalid <= 1'b0;
    drain();

    // extreme settings: widest rectangle, all-ones radiance, odd vectors
    set_light(pack_vec(-1048576, 1048575, 0), pack_vec(-One, One, -One),
              pack_vec(1048575, -1048576, 7), pack_vec(0, -1048576, 1048575),
              20'hFFFFF, 20'hFFFFF, 48'hFFFF_FFFF_FFFF);
    for (int k = 0; k < 6; k++) send_ray(rnd_ray(), 0, Miss);
    s_tvalid <= 1'b0;
    drain();
    write_reg(reg_idx_t'(3'd7), 63'h7FFF_FFFF_FFFF_FFFF);   // unknown index, ignored

    // random phases over varied lights and idling patterns
    for (int p = 0; p < 6; p++) begin
      set_light(pack_vec(rnd_coord(), rnd_coord(), rnd_coord()),
                pack_vec($signed($urandom_range(8192, 0)) - 4096,
                         $signed($urandom_range(8192, 0)) - 4096,
                         $signed($urandom_range(8192, 0)) - 4096),
                pack_vec(One, 0, $signed($urandom_range(4096, 0)) - 2048),
                pack_vec(0, One, $signed($urandom_range(4096, 0)) - 2048),
                20'($urandom_range(16384, 0)),
                (p == 5) ? 20'hFFFFF : 20'($urandom_range(16384, 0)),
                48'({$urandom, $urandom}));
      if (p == 2) begin
        send_idle = 62; recv_idle = 8;
      end else if (p == 4) begin
        send_idle = 0; recv_idle = 0;
      end
      if (p == 5) begin
        // receiver held off while rays keep coming
        fork
          begin
            hold_off = 1;
            repeat (300) @(posedge clk);
            hold_off = 0;
          end
        join_none
      end
      rnd_phase(255);
    end

    if (shade_q.size() != 0) begin
      $error("%0d results never arrived", shade_q.size());
      errors++;
    end
    $display("Sent %0d rays over %0d light settings; %0d results checked, %0d hits.",
             rays_sent, 8, shades_seen, hits_seen);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/rrl_pkg.sv
design/rrl_front.sv
design/rrl_queue.sv
design/rrl_div.sv
design/rrl_back.sv
design/ray_rectangle_light_hit.sv
design/rrl_checker.sv
bench/testbench.sv
